// ----- design/pobsf_pkg.sv -----
`default_nettype none

package pobsf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 32;

  // configuration port
  localparam int CFG_DW = 15;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_ARM_TRIP    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_DEADZONE    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DRIVE_LIMIT = 2'd2;

  localparam logic [CFG_DW-1:0] ARM_TRIP_RST    = 15'd11469;
  localparam logic [CFG_DW-1:0] DEADZONE_RST    = 15'd6554;
  localparam logic [CFG_DW-1:0] DRIVE_LIMIT_RST = 15'd20480;

  // sensor zero offsets, Q16.16
  localparam int C_ARM_ZERO   = 96368;
  localparam int C_STICK_ZERO = 43102;

  // gain magnitudes, Q16.16; signs live in the micro-op
  localparam int KW = 28;

  localparam logic [KW-1:0] K_TACHO       = 28'd2287632;
  localparam logic [KW-1:0] K_ARM_SCALE   = 28'd44663;
  localparam logic [KW-1:0] K_STICK_SCALE = 28'd48068;
  localparam logic [KW-1:0] K_ARM_MIX     = 28'd122887;
  localparam logic [KW-1:0] K_INV         = 28'd2545;
  localparam logic [KW-1:0] K_LR          = 28'd743859;
  localparam logic [KW-1:0] K_FB0         = 28'd161371724;
  localparam logic [KW-1:0] K_FB1         = 28'd29481101;
  localparam logic [KW-1:0] K_FB2         = 28'd4661130;
  localparam logic [KW-1:0] K_FB3         = 28'd12052;
  localparam logic [KW-1:0] K_OB0         = 28'd702343;
  localparam logic [KW-1:0] K_OB1         = 28'd47486;
  localparam logic [KW-1:0] K_OB2         = 28'd1411;

  typedef enum logic [2:0] {
    SRC_TACHO,
    SRC_ARMV,
    SRC_STICKV,
    SRC_ARM,
    SRC_SPEED,
    SRC_TMP,
    SRC_X1E,
    SRC_X2E
  } src_t;

  typedef enum logic [1:0] {
    ADD_ZERO,
    ADD_TMP,
    ADD_OBS,
    ADD_U
  } addend_t;

  typedef enum logic [2:0] {
    DST_SPEED,
    DST_ARM,
    DST_TMP,
    DST_X1E,
    DST_X2E,
    DST_U,
    DST_OBS
  } dst_t;

  // one multiply-accumulate step: dst = sat(addend + src * k)
  typedef struct packed {
    src_t          src;
    logic          kneg;
    logic [KW-1:0] kmag;
    addend_t       addend;
    dst_t          dst;
  } uop_t;

  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_ARM  = 4'd1;
  localparam logic [UPC_W-1:0] UPC_LAST = 4'd12;

  function automatic uop_t uop_rom(input logic [UPC_W-1:0] upc);
    uop_t u;
    unique case (upc)
      4'd0:  u = '{src: SRC_TACHO,  kneg: 1'b1, kmag: K_TACHO,
                   addend: ADD_ZERO, dst: DST_SPEED};
      4'd1:  u = '{src: SRC_ARMV,   kneg: 1'b0, kmag: K_ARM_SCALE,
                   addend: ADD_ZERO, dst: DST_ARM};
      4'd2:  u = '{src: SRC_STICKV, kneg: 1'b0, kmag: K_STICK_SCALE,
                   addend: ADD_ZERO, dst: DST_TMP};
      4'd3:  u = '{src: SRC_ARM,    kneg: 1'b0, kmag: K_ARM_MIX,
                   addend: ADD_TMP,  dst: DST_TMP};
      4'd4:  u = '{src: SRC_TMP,    kneg: 1'b1, kmag: K_INV,
                   addend: ADD_ZERO, dst: DST_X1E};
      4'd5:  u = '{src: SRC_X1E,    kneg: 1'b0, kmag: K_LR,
                   addend: ADD_OBS,  dst: DST_X2E};
      4'd6:  u = '{src: SRC_X1E,    kneg: 1'b0, kmag: K_FB0,
                   addend: ADD_ZERO, dst: DST_U};
      4'd7:  u = '{src: SRC_X2E,    kneg: 1'b0, kmag: K_FB1,
                   addend: ADD_U,    dst: DST_U};
      4'd8:  u = '{src: SRC_ARM,    kneg: 1'b0, kmag: K_FB2,
                   addend: ADD_U,    dst: DST_U};
      4'd9:  u = '{src: SRC_SPEED,  kneg: 1'b0, kmag: K_FB3,
                   addend: ADD_U,    dst: DST_U};
      4'd10: u = '{src: SRC_X1E,    kneg: 1'b1, kmag: K_OB0,
                   addend: ADD_ZERO, dst: DST_TMP};
      4'd11: u = '{src: SRC_X2E,    kneg: 1'b0, kmag: K_OB1,
                   addend: ADD_TMP,  dst: DST_TMP};
      4'd12: u = '{src: SRC_ARM,    kneg: 1'b0, kmag: K_OB2,
                   addend: ADD_TMP,  dst: DST_OBS};
      default: u = '{src: SRC_TMP,  kneg: 1'b0, kmag: '0,
                     addend: ADD_ZERO, dst: DST_TMP};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- design/pendulum_observer_state_feedback.sv -----
// Pendulum controller with a reduced-order observer. Each accepted word of three
// Q4.12 sensor voltages yields one result word: a Q4.12 motor drive and the
// latched trip flag. All internal values are signed Q16.16 in STATE_WIDTH bits,
// every product rounded to nearest and every product and sum saturated. Thirteen
// constant products run one after another through a single 16 x 28 bit multiplier,
// which takes the operand magnitude one 16-bit digit per cycle; the operand has
// NCH = ceil(STATE_WIDTH / 16) digits, and each product passes through the states
// LOAD, MAC, WB and ADD. A sample that trips stops after the arm product, and
// once tripped each sample returns zero drive until reset. in_ready is high only
// between samples; a finished result waits in the output register while the next
// sample is taken in. Registers are written through cfg_we / cfg_index / cfg_wdata
// (0: arm trip limit, 1: deadzone offset, 2: drive limit); the user must write them
// only between samples, which the block itself does not enforce.
`default_nettype none

module pendulum_observer_state_feedback
  import pobsf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0]  in_tacho_voltage,
  input  wire signed [SAMPLE_WIDTH-1:0]  in_arm_voltage,
  input  wire signed [SAMPLE_WIDTH-1:0]  in_stick_voltage,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_motor_drive,
  output logic                           out_tripped,
  input  wire                            cfg_we,
  input  wire        [CFG_IW-1:0]        cfg_index,
  input  wire        [CFG_DW-1:0]        cfg_wdata
);

  localparam int SW    = STATE_WIDTH;
  localparam int NCH   = (SW + 15) / 16;
  localparam int MW    = NCH * 16;
  localparam int AW    = MW + KW;
  localparam int RW    = AW - 16;
  localparam int EW    = ((SW > SAMPLE_WIDTH + 4) ? SW : SAMPLE_WIDTH + 4) + 2;
  localparam int CNT_W = $clog2(NCH);

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [RW-1:0] RMAX_POS = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [RW-1:0] RMAX_NEG = RMAX_POS + RW'(1);
  localparam logic signed [EW-1:0] ARM_OFS   = EW'(-C_ARM_ZERO);
  localparam logic signed [EW-1:0] STICK_OFS = EW'(-C_STICK_ZERO);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MAC,
    S_WB,
    S_ADD,
    S_CHECK,
    S_NEG,
    S_DZ,
    S_CLAMP,
    S_ROUND,
    S_EMIT
  } state_t;

  function automatic logic signed [SW-1:0] sat_e(input logic signed [EW-1:0] v);
    if (v > EW'(SMAX)) return SMAX;
    else if (v < EW'(SMIN)) return SMIN;
    else return v[SW-1:0];
  endfunction

  // widen a Q4.12 sample to Q16.16, then remove its offset
  function automatic logic signed [SW-1:0] widen(input logic signed [SAMPLE_WIDTH-1:0] s,
                                                 input logic signed [EW-1:0] ofs);
    logic signed [EW-1:0] w;
    w = EW'(s) <<< 4;
    return sat_e(EW'(sat_e(w)) + ofs);
  endfunction

  state_t st_r;
  logic [UPC_W-1:0] upc_r;
  logic [CNT_W-1:0] cnt_r;

  logic signed [SAMPLE_WIDTH-1:0] tacho_r, armv_r, stickv_r;
  logic signed [SW-1:0] speed_r, arm_r, tmp_r, x1e_r, x2e_r, u_r, obs_r, prod_r;
  logic [MW-1:0] mag_r;
  logic [KW-1:0] kmag_r;
  logic          pneg_r;
  logic [AW-1:0] acc_r;
  logic signed [SAMPLE_WIDTH-1:0] drive_r;
  logic          trip_r;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_drive_r;
  logic                           out_trip_r;

  logic [CFG_DW-1:0] cfg_trip_r, cfg_dz_r, cfg_lim_r;

  uop_t                 uop;
  logic signed [SW-1:0] opnd;
  logic [SW-1:0]        opnd_mag;
  logic [15+KW:0]       pp;
  logic [AW-1:0]        acc_nxt;
  logic [AW-1:0]        acc_rnd;
  logic [RW-1:0]        rmag;
  logic signed [SW-1:0] prod_nxt;
  logic signed [SW-1:0] addend;
  logic signed [SW-1:0] add_res;
  logic signed [EW-1:0] tlim, dz, dl;
  logic                 trip_hit;
  logic signed [SW-1:0] neg_res, dz_res, clamp_res;
  logic [SW-1:0]        umag;
  logic [SW:0]          urnd;
  logic [EW-1:0]        qe, qs;
  logic signed [SAMPLE_WIDTH-1:0] drive_nxt;

  assign uop = uop_rom(upc_r);

  // operand of the shared multiplier
  always_comb begin
    case (uop.src)
      SRC_TACHO:  opnd = widen(tacho_r, '0);
      SRC_ARMV:   opnd = widen(armv_r, ARM_OFS);
      SRC_STICKV: opnd = widen(stickv_r, STICK_OFS);
      SRC_ARM:    opnd = arm_r;
      SRC_SPEED:  opnd = speed_r;
      SRC_TMP:    opnd = tmp_r;
      SRC_X1E:    opnd = x1e_r;
      SRC_X2E:    opnd = x2e_r;
      default:    opnd = tmp_r;
    endcase
    opnd_mag = opnd[SW-1] ? (~opnd + 1'b1) : opnd;
  end

  // one digit of the magnitude per cycle, most significant first
  always_comb begin
    pp      = mag_r[MW-1 -: 16] * kmag_r;
    acc_nxt = (acc_r << 16) + AW'(pp);
  end

  // round to nearest, apply sign, saturate
  always_comb begin
    acc_rnd = acc_r + AW'(32'h8000);
    rmag    = acc_rnd[AW-1:16];
    if (!pneg_r) begin
      prod_nxt = (rmag > RMAX_POS) ? SMAX : rmag[SW-1:0];
    end else begin
      prod_nxt = (rmag > RMAX_NEG) ? SMIN : (~rmag[SW-1:0] + 1'b1);
    end
  end

  always_comb begin
    case (uop.addend)
      ADD_ZERO: addend = '0;
      ADD_TMP:  addend = tmp_r;
      ADD_OBS:  addend = obs_r;
      ADD_U:    addend = u_r;
      default:  addend = '0;
    endcase
    add_res = sat_e(EW'(addend) + EW'(prod_r));
  end

  // trip window, deadzone, clamp and output rounding
  always_comb begin
    tlim     = EW'({cfg_trip_r, 4'b0000});
    dz       = EW'({cfg_dz_r, 4'b0000});
    dl       = EW'({cfg_lim_r, 4'b0000});
    trip_hit = (EW'(arm_r) > tlim) || (EW'(arm_r) < -tlim);
    neg_res  = sat_e(-EW'(u_r));
    if (u_r > 0) dz_res = sat_e(EW'(u_r) + dz);
    else if (u_r < 0) dz_res = sat_e(EW'(u_r) - dz);
    else dz_res = u_r;
    if (EW'(u_r) > dl) clamp_res = SW'(dl);
    else if (EW'(u_r) < -dl) clamp_res = SW'(-dl);
    else clamp_res = u_r;
    umag      = u_r[SW-1] ? (~u_r + 1'b1) : u_r;
    urnd      = {1'b0, umag} + (SW+1)'(8);
    qe        = EW'(urnd[SW:4]);
    qs        = u_r[SW-1] ? (~qe + 1'b1) : qe;
    drive_nxt = qs[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      upc_r       <= '0;
      cnt_r       <= '0;
      trip_r      <= 1'b0;
      obs_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_trip_r  <= ARM_TRIP_RST;
      cfg_dz_r    <= DEADZONE_RST;
      cfg_lim_r   <= DRIVE_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ARM_TRIP:    cfg_trip_r <= cfg_wdata;
          REG_DEADZONE:    cfg_dz_r   <= cfg_wdata;
          REG_DRIVE_LIMIT: cfg_lim_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && st_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            tacho_r  <= in_tacho_voltage;
            armv_r   <= in_arm_voltage;
            stickv_r <= in_stick_voltage;
            upc_r    <= '0;
            if (trip_r) begin
              drive_r <= '0;
              st_r    <= S_EMIT;
            end else begin
              st_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          mag_r  <= MW'(opnd_mag);
          kmag_r <= uop.kmag;
          pneg_r <= opnd[SW-1] ^ uop.kneg;
          acc_r  <= '0;
          cnt_r  <= CNT_W'(NCH - 1);
          st_r   <= S_MAC;
        end
        S_MAC: begin
          acc_r <= acc_nxt;
          mag_r <= mag_r << 16;
          if (cnt_r == '0) st_r <= S_WB;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_WB: begin
          prod_r <= prod_nxt;
          st_r   <= S_ADD;
        end
        S_ADD: begin
          unique case (uop.dst)
            DST_SPEED: speed_r <= add_res;
            DST_ARM:   arm_r   <= add_res;
            DST_TMP:   tmp_r   <= add_res;
            DST_X1E:   x1e_r   <= add_res;
            DST_X2E:   x2e_r   <= add_res;
            DST_U:     u_r     <= add_res;
            DST_OBS:   obs_r   <= add_res;
            default: ;
          endcase
          if (upc_r == UPC_ARM) begin
            st_r <= S_CHECK;
          end else if (upc_r == UPC_LAST) begin
            st_r <= S_NEG;
          end else begin
            upc_r <= upc_r + UPC_W'(1);
            st_r  <= S_LOAD;
          end
        end
        S_CHECK: begin
          // arm out of the window: drop the rest and latch the trip
          if (trip_hit) begin
            trip_r  <= 1'b1;
            drive_r <= '0;
            st_r    <= S_EMIT;
          end else begin
            upc_r <= upc_r + UPC_W'(1);
            st_r  <= S_LOAD;
          end
        end
        S_NEG: begin
          u_r  <= neg_res;
          st_r <= S_DZ;
        end
        S_DZ: begin
          u_r  <= dz_res;
          st_r <= S_CLAMP;
        end
        S_CLAMP: begin
          u_r  <= clamp_res;
          st_r <= S_ROUND;
        end
        S_ROUND: begin
          drive_r <= drive_nxt;
          st_r    <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the previous word has left the output register
          if (!out_valid_r || out_ready) begin
            out_drive_r <= drive_r;
            out_trip_r  <= trip_r;
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (st_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_motor_drive = out_drive_r;
  assign out_tripped     = out_trip_r;

endmodule

`default_nettype wire

// ----- design/pobsf_checker.sv -----
`default_nettype none

module pobsf_checker
  import pobsf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire signed [SAMPLE_WIDTH-1:0] out_motor_drive,
  input wire                           out_tripped,
  input wire                           cfg_we,
  input wire        [CFG_IW-1:0]       cfg_index,
  input wire        [CFG_DW-1:0]       cfg_wdata
);

  localparam int CW = ((SAMPLE_WIDTH > CFG_DW) ? SAMPLE_WIDTH : CFG_DW) + 1;
  localparam logic [CW-1:0] HALF = CW'(1) << (SAMPLE_WIDTH - 1);

  logic              seen_trip_r;
  logic [CFG_DW-1:0] lim_r;
  logic [SAMPLE_WIDTH-1:0] drv_mag;
  logic              lim_fits;
  logic              sample_seen;

  assign drv_mag  = out_motor_drive[SAMPLE_WIDTH-1] ? (~out_motor_drive + 1'b1)
                                                    : out_motor_drive;
  assign lim_fits = CW'(lim_r) < HALF;
  assign sample_seen = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_trip_r <= 1'b0;
      lim_r       <= DRIVE_LIMIT_RST;
    end else begin
      if (out_valid && out_ready && out_tripped) seen_trip_r <= 1'b1;
      if (cfg_we && cfg_index == REG_DRIVE_LIMIT) lim_r <= cfg_wdata;
    end
  end

  a_trip_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_trip_r |-> out_tripped)
    else $error("trip flag dropped after a trip");

  a_trip_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tripped |-> out_motor_drive == '0)
    else $error("drive not zero while tripped");

  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && lim_fits |-> CW'(drv_mag) <= CW'(lim_r))
    else $error("drive beyond the drive limit");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    sample_seen |=> !in_ready)
    else $error("ready again straight after taking a word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_drive) &&
                                $stable(out_tripped))
    else $error("stalled result word changed");

endmodule

bind pendulum_observer_state_feedback pobsf_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_pobsf_checker (.*);

`default_nettype wire

// ----- test/tb_pendulum_observer_state_feedback.sv -----
`timescale 1ns / 100ps

module tb_pendulum_observer_state_feedback;
  import pobsf_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

  // Q16.16 gains and offsets
  localparam longint TACHO_GAIN   = -2287632;
  localparam longint ARM_OFFSET   = 96368;
  localparam longint STICK_OFFSET = 43102;
  localparam longint STICK_GAIN   = 48068;
  localparam longint ARM_GAIN     = 44663;
  localparam longint INV_GAIN     = -2545;
  localparam longint ARM_MIX      = 122887;
  localparam longint OBS_GAIN     = 743859;
  localparam longint FB_X1E       = 161371724;
  localparam longint FB_X2E       = 29481101;
  localparam longint FB_ARM       = 4661130;
  localparam longint FB_SPEED     = 12052;
  localparam longint UPD_X1E      = -702343;
  localparam longint UPD_X2E      = 47486;
  localparam longint UPD_ARM      = 1411;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // sensor voltages that put arm and stick at their zero points
  localparam int ARM_BALANCE   = 6023;
  localparam int STICK_BALANCE = 2694;

  typedef struct packed {
    logic signed [SW-1:0] tacho;
    logic signed [SW-1:0] arm;
    logic signed [SW-1:0] stick;
  } sample_t;

  typedef struct packed {
    logic signed [SW-1:0] drive;
    logic                 tripped;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] in_tacho_voltage = '0;
  logic signed [SW-1:0] in_arm_voltage = '0;
  logic signed [SW-1:0] in_stick_voltage = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] out_motor_drive;
  logic                 out_tripped;
  logic                 cfg_we = 1'b0;
  logic [CFG_IW-1:0]    cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  pendulum_observer_state_feedback u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tacho_voltage (in_tacho_voltage),
    .in_arm_voltage   (in_arm_voltage),
    .in_stick_voltage (in_stick_voltage),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_motor_drive  (out_motor_drive),
    .out_tripped      (out_tripped),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // controller state as the block should hold it
  longint            obs_state = 0;
  logic              trip_seen = 1'b0;
  logic [CFG_DW-1:0] trip_lim = ARM_TRIP_RST;
  logic [CFG_DW-1:0] dz_off = DEADZONE_RST;
  logic [CFG_DW-1:0] drv_lim = DRIVE_LIMIT_RST;

  sample_t pending_words[$];
  drive_t  drive_due[$];
  int      words_in_flight = 0;
  int      mismatches = 0;
  int      cycles = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_odds = 0;
  int stall_phase = 0;

  function automatic longint q_sat(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint q_add(longint a, longint b);
    return q_sat(a + b);
  endfunction

  // rounded to nearest, ties away from zero
  function automatic longint q_mul(longint v, longint c);
    longint unsigned m, mc, r;
    longint s;
    m = (v < 0) ? -v : v;
    mc = (c < 0) ? -c : c;
    r = (m >> 16) * mc + (((m & 64'hFFFF) * mc + 64'h8000) >> 16);
    s = longint'(r);
    return q_sat(((v < 0) != (c < 0)) ? -s : s);
  endfunction

  function automatic longint widen(logic signed [SW-1:0] v);
    return q_sat(longint'(v) * 16);
  endfunction

  function automatic longint arm_angle(logic signed [SW-1:0] av);
    return q_mul(q_add(widen(av), -ARM_OFFSET), ARM_GAIN);
  endfunction

  function automatic logic would_trip(logic signed [SW-1:0] av);
    longint a, lim;
    a = arm_angle(av);
    lim = longint'(trip_lim) * 16;
    return (a > lim) || (a < -lim);
  endfunction

  function automatic drive_t run_controller(logic signed [SW-1:0] tv, logic signed [SW-1:0] av,
                                            logic signed [SW-1:0] sv);
    drive_t r;
    longint speed, arm, stick, x1e, x2e, u, lim, dz, q;
    longint unsigned um;
    r.drive = '0;
    r.tripped = 1'b1;
    if (!trip_seen) begin
      speed = q_mul(widen(tv), TACHO_GAIN);
      arm = arm_angle(av);
      lim = longint'(trip_lim) * 16;
      if (arm > lim || arm < -lim) begin
        trip_seen = 1'b1;
      end else begin
        stick = q_mul(q_add(widen(sv), -STICK_OFFSET), STICK_GAIN);
        x1e = q_mul(q_add(stick, q_mul(arm, ARM_MIX)), INV_GAIN);
        x2e = q_add(obs_state, q_mul(x1e, OBS_GAIN));
        u = q_add(q_mul(x1e, FB_X1E), q_mul(x2e, FB_X2E));
        u = q_add(u, q_mul(arm, FB_ARM));
        u = q_add(u, q_mul(speed, FB_SPEED));
        u = q_sat(-u);
        // no deadzone push on an exact zero
        dz = longint'(dz_off) * 16;
        if (u > 0) u = q_add(u, dz);
        else if (u < 0) u = q_add(u, -dz);
        lim = longint'(drv_lim) * 16;
        if (u > lim) u = lim;
        if (u < -lim) u = -lim;
        um = (u < 0) ? -u : u;
        um = (um + 8) >> 4;
        q = longint'(um);
        if (u < 0) q = -q;
        obs_state = q_add(q_add(q_mul(x1e, UPD_X1E), q_mul(x2e, UPD_X2E)), q_mul(arm, UPD_ARM));
        r.drive = q[SW-1:0];
        r.tripped = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int rand_dev(int k);
    int span;
    span = 1 << k;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly near balance with random spread; the rest wide or noisy
  function automatic sample_t pick_sample();
    sample_t s;
    int k, tries;
    k = $urandom_range(0, 11);
    tries = 0;
    do begin
      if ($urandom_range(0, 9) < 7) begin
        s.tacho = SW'(rand_dev(k));
        s.arm = SW'(ARM_BALANCE + rand_dev(k));
        s.stick = SW'(STICK_BALANCE + rand_dev(k));
        if ($urandom_range(0, 15) == 0) s.tacho = SW'($urandom);
        if ($urandom_range(0, 15) == 0) s.stick = SW'($urandom);
      end else if (trip_lim == '1) begin
        s.tacho = SW'($urandom);
        s.arm = SW'($urandom);
        s.stick = SW'($urandom);
      end else begin
        s.tacho = SW'(int'($urandom_range(0, 40960)) - 20480);
        s.arm = SW'(int'($urandom_range(0, 40960)) - 20480);
        s.stick = SW'(int'($urandom_range(0, 40960)) - 20480);
      end
      tries++;
    end while (would_trip(s.arm) && tries < 8);
    // hold the arm inside the window; a trip is final
    if (would_trip(s.arm)) s.arm = SW'(ARM_BALANCE);
    return s;
  endfunction

  function automatic logic [CFG_DW-1:0] pick_reg(int lo_pick);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 15'd20480;
      2: return '1;
      default: return CFG_DW'($urandom_range(lo_pick, 20480));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ARM_TRIP:    trip_lim = val;
      REG_DEADZONE:    dz_off = val;
      REG_DRIVE_LIMIT: drv_lim = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_word(int tv, int av, int sv);
    sample_t s;
    s.tacho = SW'(tv);
    s.arm = SW'(av);
    s.stick = SW'(sv);
    pending_words.push_back(s);
    words_in_flight++;
  endtask

  task automatic drain();
    while (words_in_flight != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic void note_mismatch(drive_t want, logic have_want);
    if (mismatches < 10) begin
      if (have_want)
        $display("mismatch: drive exp %0d got %0d, tripped exp %0b got %0b",
                 want.drive, out_motor_drive, want.tripped, out_tripped);
      else
        $display("unexpected word: drive %0d tripped %0b", out_motor_drive, out_tripped);
    end
    mismatches++;
  endfunction

  // sender: bursts of words with random gaps
  always @(posedge clk) begin : sender
    logic v;
    sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid && !in_ready;
      if (in_valid && in_ready)
        drive_due.push_back(run_controller(in_tacho_voltage, in_arm_voltage, in_stick_voltage));
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          s = pending_words.pop_front();
          in_tacho_voltage <= s.tacho;
          in_arm_voltage <= s.arm;
          in_stick_voltage <= s.stick;
          v = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 8);
              2: gap_left = $urandom_range(9, 80);
              default: gap_left = $urandom_range(81, 200);
            endcase
          end
        end
      end
      in_valid <= v;
    end
  end

  // receiver: stall pattern picked anew each time stall_phase wraps
  always @(posedge clk) begin : receiver
    drive_t want;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (words_in_flight > 0) words_in_flight--;
        if (drive_due.size() == 0) begin
          want = '0;
          note_mismatch(want, 1'b0);
        end else begin
          want = drive_due.pop_front();
          if (out_motor_drive !== want.drive || out_tripped !== want.tripped)
            note_mismatch(want, 1'b1);
        end
      end
      stall_phase++;
      if (stall_phase == 256) begin
        stall_phase = 0;
        stall_odds = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        case (stall_odds)
          1: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
          2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 30);
          3: if ($urandom_range(0, 31) == 0) stall_left = $urandom_range(60, 160);
          default: ;
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pendulum_observer_state_feedback NOT OK");
      $finish;
    end
  end

  initial begin
    int ph, n, edge_pos, edge_neg;
    longint a;
    sample_t s;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero drive at balance, field extremes inside the window
    queue_word(0, ARM_BALANCE, STICK_BALANCE);
    queue_word(20480, ARM_BALANCE, STICK_BALANCE);
    queue_word(-20480, ARM_BALANCE, STICK_BALANCE);
    queue_word(0, ARM_BALANCE, 20480);
    queue_word(0, ARM_BALANCE, -20480);
    queue_word(0, 20480, STICK_BALANCE);
    queue_word(37, 6100, 2650);
    drain();

    // widest window: full-scale words, saturation
    write_reg(REG_ARM_TRIP, '1);
    write_reg(REG_DEADZONE, '0);
    queue_word(-32768, -32768, -32768);
    queue_word(32767, 32767, 32767);
    queue_word(-20480, -20480, -20480);
    queue_word(0, 0, 0);
    queue_word(16'sh5555, 16'shAAAA - 65536, 16'sh5555);
    drain();

    write_reg(REG_DEADZONE, 15'd20480);
    write_reg(REG_DRIVE_LIMIT, '0);
    queue_word(100, ARM_BALANCE, 2700);
    queue_word(-100, ARM_BALANCE, 2690);
    drain();

    write_reg(REG_DEADZONE, '1);
    write_reg(REG_DRIVE_LIMIT, '1);
    write_reg(REG_UNUSED, '1);
    queue_word(0, ARM_BALANCE, 2695);
    queue_word(-5, ARM_BALANCE, 2693);
    drain();

    // window edges: find arm voltages whose angle lands on a limit step
    edge_pos = ARM_BALANCE + 1;
    while ((arm_angle(SW'(edge_pos)) % 16) != 0) edge_pos++;
    edge_neg = ARM_BALANCE - 1;
    while ((arm_angle(SW'(edge_neg)) % 16) != 0) edge_neg--;
    a = arm_angle(SW'(edge_pos));
    write_reg(REG_ARM_TRIP, CFG_DW'(a / 16));
    queue_word(12, edge_pos, STICK_BALANCE);
    drain();
    a = arm_angle(SW'(edge_neg));
    write_reg(REG_ARM_TRIP, CFG_DW'(-a / 16));
    queue_word(-12, edge_neg, STICK_BALANCE);
    drain();
    write_reg(REG_ARM_TRIP, '0);
    queue_word(0, ARM_BALANCE, STICK_BALANCE);
    queue_word(100, ARM_BALANCE, 3000);
    drain();

    for (ph = 0; ph < 12; ph++) begin
      write_reg(REG_ARM_TRIP, ($urandom_range(0, 1) == 0) ? '1 : pick_reg(2000));
      write_reg(REG_DEADZONE, pick_reg(0));
      write_reg(REG_DRIVE_LIMIT, pick_reg(0));
      for (n = 0; n < 110; n++) begin
        s = pick_sample();
        pending_words.push_back(s);
        words_in_flight++;
      end
      drain();
    end

    // trip just past the edge, then the latch holds
    write_reg(REG_DRIVE_LIMIT, 15'd20480);
    write_reg(REG_ARM_TRIP, CFG_DW'(arm_angle(SW'(edge_pos)) / 16));
    queue_word(0, edge_pos, STICK_BALANCE);
    queue_word(0, edge_pos + 1, STICK_BALANCE);
    queue_word(0, ARM_BALANCE, STICK_BALANCE);
    queue_word($urandom, $urandom, $urandom);
    queue_word(-300, ARM_BALANCE, 2600);
    drain();

    if (drive_due.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("tb_pendulum_observer_state_feedback OK");
    else
      $display("tb_pendulum_observer_state_feedback NOT OK");
    $finish;
  end

endmodule
